// ===== rtl/bptc_pkg.sv =====
// Shared types, constants and helper functions of the barometric compensation block.
package bptc_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  // Compensation constants.
  localparam logic [31:0] T_OFFSET   = 32'd4000;
  localparam logic [31:0] P_LIN      = 32'd3038;
  localparam logic [31:0] P_QUAD     = 32'd7357;
  localparam logic [31:0] P_OFFSET   = 32'd3791;
  localparam logic [31:0] P_SCALE    = 32'd50000;
  localparam logic [31:0] B4_OFFSET  = 32'd32768;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

  // Calibration coefficients as raw 16-bit words plus the oversampling setting.
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
  } fr_item_t;

  // Working set carried down the back pipeline.
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        err;
    logic        neg;
    logic        dbl;
    logic [31:0] n;
    logic [31:0] d;
    logic [31:0] b5;
    logic [31:0] b6;
    logic        tneg;
    logic [31:0] tmag;
    logic [15:0] temp;
    logic [31:0] m_sq;
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [31:0] sq;
    logic [31:0] xa;
    logic [31:0] xb;
    logic [31:0] m_c;
    logic [31:0] m_d;
    logic [31:0] b3n;
    logic [31:0] x3b;
    logic [31:0] b3;
    logic [31:0] b4;
    logic [31:0] p;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] y1;
    logic [31:0] y2;
  } work_t;

  // Arithmetic shift right of a 32-bit pattern.
  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] sh);
    return 32'($signed(x) >>> sh);
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Top level: configuration registers, front part, queue and back part.
// Throughput: one item per cycle unless the output stalls;
// each of the two dividers retires one quotient bit per stage.
// Stalls on the output freeze the back pipeline; the queue lets the front keep taking items.
// Reset (synchronous, active low) clears all control state and all calibration registers.
module baro_pressure_temp_compensation #(
  parameter int QDEPTH = bptc_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // raw_temp[15:0], raw_press[34:16], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // pressure_pa[31:0], temp_deg[47:32], div_error[48], zero pad
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] ac1_ac2_r, ac3_ac4_r, ac5_ac6_r, b1_b2_r, mc_md_r;
  logic [1:0]  oss_r;

  bptc_pkg::cal_t     cal;
  bptc_pkg::fr_item_t f_item, q_item;
  logic               push, pop, q_full, q_empty;
  logic [31:0]        pressure_pa;
  logic [15:0]        temp_deg;
  logic               div_error;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_ac2_r <= '0;
      ac3_ac4_r <= '0;
      ac5_ac6_r <= '0;
      b1_b2_r   <= '0;
      mc_md_r   <= '0;
      oss_r     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        bptc_pkg::REG_AC1_AC2: ac1_ac2_r <= cfg_wdata;
        bptc_pkg::REG_AC3_AC4: ac3_ac4_r <= cfg_wdata;
        bptc_pkg::REG_AC5_AC6: ac5_ac6_r <= cfg_wdata;
        bptc_pkg::REG_B1_B2:   b1_b2_r   <= cfg_wdata;
        bptc_pkg::REG_MC_MD:   mc_md_r   <= cfg_wdata;
        bptc_pkg::REG_OSS:     oss_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Unpacked coefficients.
  always_comb begin
    cal.ac1 = ac1_ac2_r[31:16];
    cal.ac2 = ac1_ac2_r[15:0];
    cal.ac3 = ac3_ac4_r[31:16];
    cal.ac4 = ac3_ac4_r[15:0];
    cal.ac5 = ac5_ac6_r[31:16];
    cal.ac6 = ac5_ac6_r[15:0];
    cal.b1  = b1_b2_r[31:16];
    cal.b2  = b1_b2_r[15:0];
    cal.mc  = mc_md_r[31:16];
    cal.md  = mc_md_r[15:0];
    cal.oss = oss_r;
  end

  bptc_front u_front (
    .clk(clk), .rst_n(rst_n), .cal(cal),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .raw_temp(in_tdata[15:0]), .raw_press(in_tdata[34:16]),
    .q_full(q_full), .push(push), .item(f_item)
  );

  bptc_fifo #(.DEPTH(QDEPTH), .W($bits(bptc_pkg::fr_item_t))) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_data(f_item),
    .pop(pop), .rd_data(q_item),
    .full(q_full), .empty(q_empty)
  );

  bptc_back u_back (
    .clk(clk), .rst_n(rst_n), .cal(cal),
    .q_empty(q_empty), .q_item(q_item), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .pressure_pa(pressure_pa), .temp_deg(temp_deg), .div_error(div_error)
  );

  assign out_tdata = {7'd0, div_error, temp_deg, pressure_pa};

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[48] |-> out_tdata[47:0] == '0)
    else $error("result fields not zero on a divide error");
`endif

endmodule

// ===== rtl/bptc_fifo.sv =====
// Short queue that decouples the front part from the back part.
module bptc_fifo #(
  parameter int DEPTH = bptc_pkg::QDEPTH,
  parameter int W     = $bits(bptc_pkg::fr_item_t)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue fill count beyond depth");
  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + CW'(1)) else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/bptc_front.sv =====
// Front part: takes input items and computes the first temperature term.
module bptc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  bptc_pkg::cal_t     cal,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        raw_temp,
  input  logic [18:0]        raw_press,
  input  logic               q_full,
  output logic               push,
  output bptc_pkg::fr_item_t item
);

  logic               v_r;
  bptc_pkg::fr_item_t item_r, item_nxt;
  logic [31:0]        diff;

  assign in_ready = !v_r || !q_full;
  assign push     = v_r && !q_full;
  assign item     = item_r;

  // X1 = ((UT - AC6) * AC5) >> 15.
  always_comb begin
    diff        = {16'd0, raw_temp} - {16'd0, cal.ac6};
    item_nxt.x1 = bptc_pkg::asr(32'(diff * {16'd0, cal.ac5}), 5'd15);
    item_nxt.up = raw_press;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/bptc_div.sv =====
// Pipelined unsigned divider, one quotient bit per stage, with a carried sideband.
module bptc_div #(
  parameter int W  = 32,
  parameter int SW = $bits(bptc_pkg::work_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [W-1:0]  quotient,
  output logic [SW-1:0] side_out
);

  logic [W-1:0]  rem_s  [W+1];
  logic [W-1:0]  quo_s  [W+1];
  logic [W-1:0]  dvs_s  [W+1];
  logic [SW-1:0] side_s [W+1];
  logic          v_s    [W+1];

  assign rem_s[0]  = '0;
  assign quo_s[0]  = dividend;
  assign dvs_s[0]  = divisor;
  assign side_s[0] = side_in;
  assign v_s[0]    = in_valid;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0]    trial;
    logic          bit_q;
    logic [W-1:0]  rem_nxt, quo_nxt;
    logic [W-1:0]  rem_r, quo_r, dvs_r;
    logic [SW-1:0] side_r;
    logic          v_r;

    // Restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb begin
      trial   = {rem_s[i], quo_s[i][W-1]};
      bit_q   = (trial >= {1'b0, dvs_s[i]});
      rem_nxt = bit_q ? W'(trial - {1'b0, dvs_s[i]}) : trial[W-1:0];
      quo_nxt = {quo_s[i][W-2:0], bit_q};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        dvs_r  <= dvs_s[i];
        side_r <= side_s[i];
      end
    end

    assign rem_s[i+1]  = rem_r;
    assign quo_s[i+1]  = quo_r;
    assign dvs_s[i+1]  = dvs_r;
    assign side_s[i+1] = side_r;
    assign v_s[i+1]    = v_r;
  end

  assign out_valid = v_s[W];
  assign quotient  = quo_s[W];
  assign side_out  = side_s[W];

endmodule

// ===== rtl/bptc_back.sv =====
// Back part: pipelined compensation arithmetic with two dividers and the output register.
module bptc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bptc_pkg::cal_t     cal,
  input  logic               q_empty,
  input  bptc_pkg::fr_item_t q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        pressure_pa,
  output logic [15:0]        temp_deg,
  output logic               div_error
);

  localparam int NS = 12;
  localparam int SW = $bits(bptc_pkg::work_t);

  logic            en;
  bptc_pkg::work_t w_r [NS];
  logic            v_r [NS];
  bptc_pkg::work_t nx  [NS];
  logic            nv  [NS];

  logic            da_v, db_v;
  logic [31:0]     da_q, db_q;
  logic [SW-1:0]   da_side, db_side;
  bptc_pkg::work_t da_w, db_w;

  logic            out_v_r;
  logic [31:0]     p_out_r, p_out_nxt;
  logic [15:0]     t_out_r, t_out_nxt;
  logic            e_out_r;

  assign en  = !out_v_r || out_ready;
  assign pop = en && !q_empty;

  assign da_w = bptc_pkg::work_t'(da_side);
  assign db_w = bptc_pkg::work_t'(db_side);

  // Temperature divider: magnitude of (MC << 11) over magnitude of (X1 + MD).
  bptc_div #(.W(32), .SW(SW)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v_r[0]), .dividend(w_r[0].n), .divisor(w_r[0].d), .side_in(SW'(w_r[0])),
    .out_valid(da_v), .quotient(da_q), .side_out(da_side)
  );

  // Pressure divider: B7 (doubled when it fits) over B4.
  bptc_div #(.W(32), .SW(SW)) u_div_p (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v_r[8]), .dividend(w_r[8].n), .divisor(w_r[8].d), .side_in(SW'(w_r[8])),
    .out_valid(db_v), .quotient(db_q), .side_out(db_side)
  );

  // Stage arithmetic.
  always_comb begin
    logic [31:0] den, a, x2, tv, tsg, x3, b7, pq, s8;
    // Stage 0: divisor and sign setup for the temperature division.
    nx[0]     = '0;
    nx[0].x1  = q_item.x1;
    nx[0].up  = q_item.up;
    den       = q_item.x1 + bptc_pkg::sx16(cal.md);
    a         = bptc_pkg::sx16(cal.mc) << 11;
    nx[0].err = (den == '0);
    nx[0].neg = a[31] ^ den[31];
    nx[0].n   = a[31] ? -a : a;
    nx[0].d   = den[31] ? -den : den;
    nv[0]     = pop;

    // Stage 1: B5 = X1 + X2.
    nx[1]    = da_w;
    x2       = da_w.neg ? -da_q : da_q;
    nx[1].b5 = da_w.x1 + x2;
    nv[1]    = da_v;

    // Stage 2: tenth-degree value and B6.
    nx[2]      = w_r[1];
    tv         = bptc_pkg::asr(w_r[1].b5 + 32'd8, 5'd4);
    nx[2].tneg = tv[31];
    nx[2].tmag = tv[31] ? -tv : tv;
    nx[2].b6   = w_r[1].b5 - bptc_pkg::T_OFFSET;
    nv[2]      = v_r[1];

    // Stage 3: divide by ten through the reciprocal, and the B6 products.
    nx[3]      = w_r[2];
    nx[3].tmag = 32'((64'(w_r[2].tmag) * 64'(bptc_pkg::RECIP_TEN)) >> 35);
    nx[3].m_sq = 32'(w_r[2].b6 * w_r[2].b6);
    nx[3].m_a  = 32'(bptc_pkg::sx16(cal.ac2) * w_r[2].b6);
    nx[3].m_b  = 32'(bptc_pkg::sx16(cal.ac3) * w_r[2].b6);
    nv[3]      = v_r[2];

    // Stage 4: signed, saturated temperature and scaled terms.
    nx[4] = w_r[3];
    tsg   = w_r[3].tneg ? -w_r[3].tmag : w_r[3].tmag;
    priority if ($signed(tsg) > 32'sd32767) begin
      nx[4].temp = 16'h7FFF;
    end else if ($signed(tsg) < -32'sd32768) begin
      nx[4].temp = 16'h8000;
    end else begin
      nx[4].temp = tsg[15:0];
    end
    nx[4].sq = bptc_pkg::asr(w_r[3].m_sq, 5'd12);
    nx[4].xa = bptc_pkg::asr(w_r[3].m_a, 5'd11);
    nx[4].xb = bptc_pkg::asr(w_r[3].m_b, 5'd13);
    nv[4]    = v_r[3];

    // Stage 5: products with the squared term.
    nx[5]     = w_r[4];
    nx[5].m_c = 32'(bptc_pkg::sx16(cal.b2) * w_r[4].sq);
    nx[5].m_d = 32'(bptc_pkg::sx16(cal.b1) * w_r[4].sq);
    nv[5]     = v_r[4];

    // Stage 6: B3 numerator and the B4 term.
    nx[6]     = w_r[5];
    x3        = bptc_pkg::asr(w_r[5].m_c, 5'd11) + w_r[5].xa;
    nx[6].b3n = ((32'(bptc_pkg::sx16(cal.ac1) << 2) + x3) << cal.oss) + 32'd2;
    nx[6].x3b = bptc_pkg::asr(w_r[5].xb + bptc_pkg::asr(w_r[5].m_d, 5'd16) + 32'd2, 5'd2);
    nv[6]     = v_r[5];

    // Stage 7: B3 by a truncating divide by four, and B4.
    nx[7]    = w_r[6];
    nx[7].b3 = bptc_pkg::asr(w_r[6].b3n + (w_r[6].b3n[31] ? 32'd3 : 32'd0), 5'd2);
    nx[7].b4 = 32'({16'd0, cal.ac4} * (w_r[6].x3b + bptc_pkg::B4_OFFSET)) >> 15;
    nv[7]    = v_r[6];

    // Stage 8: B7 and the pressure dividend.
    nx[8]     = w_r[7];
    b7        = 32'(({13'd0, w_r[7].up} - w_r[7].b3) * (bptc_pkg::P_SCALE >> cal.oss));
    nx[8].err = w_r[7].err || (w_r[7].b4 == '0);
    nx[8].dbl = b7[31];
    nx[8].n   = b7[31] ? b7 : b7 << 1;
    nx[8].d   = w_r[7].b4;
    nv[8]     = v_r[7];

    // Stage 9: pressure before the final correction.
    nx[9]   = db_w;
    pq      = db_w.dbl ? db_q << 1 : db_q;
    nx[9].p = pq;
    nv[9]   = db_v;

    // Stage 10: correction products.
    nx[10]    = w_r[9];
    s8        = bptc_pkg::asr(w_r[9].p, 5'd8);
    nx[10].m1 = 32'(s8 * s8);
    nx[10].m2 = 32'(32'd0 - 32'(bptc_pkg::P_QUAD * w_r[9].p));
    nv[10]    = v_r[9];

    // Stage 11: scaled correction terms.
    nx[11]    = w_r[10];
    nx[11].y1 = bptc_pkg::asr(32'(w_r[10].m1 * bptc_pkg::P_LIN), 5'd16);
    nx[11].y2 = bptc_pkg::asr(w_r[10].m2, 5'd16);
    nv[11]    = v_r[10];
  end

  // Final sum, zeroed on a divide error.
  always_comb begin
    p_out_nxt = w_r[11].p
              + bptc_pkg::asr(w_r[11].y1 + w_r[11].y2 + bptc_pkg::P_OFFSET, 5'd4);
    t_out_nxt = w_r[11].temp;
    if (w_r[11].err) begin
      p_out_nxt = '0;
      t_out_nxt = '0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_pipe
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= nv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[i] <= nx[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[11];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out_r <= p_out_nxt;
      t_out_r <= t_out_nxt;
      e_out_r <= w_r[11].err;
    end
  end

  assign out_valid   = out_v_r;
  assign pressure_pa = p_out_r;
  assign temp_deg    = t_out_r;
  assign div_error   = e_out_r;

endmodule

// ===== tb/baro_pressure_temp_compensation_tb.sv =====
// Testbench for the barometric compensation block: random stream traffic checked against a predictor.
module baro_pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One compensated result as the block reports it.
  typedef struct {
    logic [31:0] press;
    logic [15:0] temp;
    logic        err;
  } comp_res_t;

  // Holds the calibration copy, predicts results and checks them in order.
  class comp_scoreboard;
    logic [31:0] cal[6];
    comp_res_t   pending[$];
    int          mismatches;

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      if (idx <= bptc_pkg::REG_OSS)
        cal[idx] = (idx == bptc_pkg::REG_OSS) ? (val & 32'd3) : val;
    endfunction

    function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
      if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
      return 32'($signed(a) / $signed(b));
    endfunction

    function logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
    endfunction

    // Integer compensation of one raw temperature and pressure pair.
    function comp_res_t compensate(logic [15:0] ut, logic [18:0] up);
      comp_res_t r;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den;
      int oss, t;
      ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
      ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
      ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
      ac4 = {16'd0, cal[1][15:0]};
      ac5 = {16'd0, cal[2][31:16]};
      ac6 = {16'd0, cal[2][15:0]};
      b1 = {{16{cal[3][31]}}, cal[3][31:16]};
      b2 = {{16{cal[3][15]}}, cal[3][15:0]};
      mc = {{16{cal[4][31]}}, cal[4][31:16]};
      md = {{16{cal[4][15]}}, cal[4][15:0]};
      oss = cal[5][1:0];
      r = '{press: 32'd0, temp: 16'd0, err: 1'b1};
      x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) return r;
      x2 = sdiv(mc << 11, den);
      b5 = x1 + x2;
      t = $signed(sra(b5 + 32'd8, 4)) / 10;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      b6 = b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sdiv(((ac1 * 32'd4 + x3) << oss) + 32'd2, 32'd4);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = ({13'd0, up} - b3) * (32'd50000 >> oss);
      if (!b7[31]) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra(32'd0 - 32'd7357 * p, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      r = '{press: p, temp: t[15:0], err: 1'b0};
      return r;
    endfunction

    function void note_input(logic [39:0] d);
      pending.push_back(compensate(d[15:0], d[34:16]));
    endfunction

    function void check_result(logic [55:0] d);
      comp_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.press || d[47:32] !== e.temp || d[48] !== e.err
          || d[55:49] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected p=%h t=%h e=%b, got p=%h t=%h e=%b",
                   e.press, e.temp, e.err, d[31:0], d[47:32], d[48]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // raw_temp[15:0], raw_press[34:16], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // pressure_pa[31:0], temp_deg[47:32], div_error[48], zero pad
  logic        cfg_wen;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  comp_scoreboard sb;
  bit  quiet;
  bit  sink_on;
  int  cycles;

  baro_pressure_temp_compensation u_top (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitors on both channels.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Result side stalls in random bursts.
  initial begin
    out_tready = 1'b0;
    wait (sink_on);
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Sends one item; caller is at a falling edge.
  task automatic send_item(logic [15:0] ut, logic [18:0] up);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, up, ut};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Typical factory calibration, as a realistic baseline.
  task automatic load_typical();
    write_reg(bptc_pkg::REG_AC1_AC2, {16'd408, 16'hFFC8});
    write_reg(bptc_pkg::REG_AC3_AC4, {16'hC6D1, 16'd32741});
    write_reg(bptc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
    write_reg(bptc_pkg::REG_B1_B2, {16'd6190, 16'd4});
    write_reg(bptc_pkg::REG_MC_MD, {16'h8000 + 16'd32768 - 16'd8711, 16'd2868});
  endtask

  task automatic random_cal();
    write_reg(bptc_pkg::REG_AC1_AC2, $urandom);
    write_reg(bptc_pkg::REG_AC3_AC4, $urandom);
    write_reg(bptc_pkg::REG_AC5_AC6, $urandom);
    write_reg(bptc_pkg::REG_B1_B2, $urandom);
    write_reg(bptc_pkg::REG_MC_MD, $urandom);
  endtask

  initial begin
    logic [15:0] ut;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    cycles = 0;
    quiet = 0;
    for (int i = 0; i < 6; i++) sb.cal[i] = 32'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    sink_on = 1;

    // Reset calibration: every divisor is zero.
    send_item(16'd0, 19'd0);
    send_item(16'hFFFF, 19'h7FFFF);
    drain();

    // Directed: extremes under a typical calibration and each oversampling.
    load_typical();
    for (int o = 0; o < 4; o++) begin
      write_reg(bptc_pkg::REG_OSS, o);
      send_item(16'd27898, 19'd23843 << o);
      send_item(16'd0, 19'd0);
      send_item(16'hFFFF, 19'h7FFFF);
      send_item(16'h5555, 19'h2AAAA);
      drain();
    end
    // Zero temperature divisor: MC and MD zero with AC5 zero.
    write_reg(bptc_pkg::REG_AC5_AC6, 32'd0);
    write_reg(bptc_pkg::REG_MC_MD, 32'd0);
    send_item(16'd1234, 19'd1000);
    drain();
    // Zero pressure divisor: AC4 zero.
    load_typical();
    write_reg(bptc_pkg::REG_AC3_AC4, {16'hC6D1, 16'd0});
    send_item(16'd27898, 19'd23843);
    drain();
    // Temperature division with MC at its minimum and a divisor of -1.
    write_reg(bptc_pkg::REG_AC5_AC6, 32'd0);
    write_reg(bptc_pkg::REG_MC_MD, {16'h8000, 16'hFFFF});
    write_reg(bptc_pkg::REG_AC3_AC4, {16'h7FFF, 16'hFFFF});
    send_item(16'd0, 19'd0);
    send_item(16'hFFFF, 19'h7FFFF);
    drain();
    write_reg(bptc_pkg::REG_MC_MD, {16'h8000, 16'h0001});
    write_reg(bptc_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
    send_item(16'hFFFF, 19'd5);
    drain();
    // Index beyond the register list is ignored.
    write_reg(3'd7, 32'hDEAD_BEEF);
    write_reg(3'd6, 32'h1234_5678);

    // Random phases alternating realistic and random calibrations.
    for (int ph = 0; ph < 16; ph++) begin
      if (ph % 2 == 0) load_typical();
      else random_cal();
      write_reg(bptc_pkg::REG_OSS, $urandom_range(0, 3));
      if (ph == 15) quiet = 1;
      for (int i = 0; i < 100; i++) begin
        ut = (ph % 2 == 0 && $urandom_range(0, 3) != 0) ?
             16'($urandom_range(20000, 36000)) : 16'($urandom);
        send_item(ut, 19'($urandom));
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
